>>> rtl/rrd_pkg.sv
// shared widths and helpers for the reflected ray direction pipeline
package rrd_pkg;

   localparam int PRE_BITS  = 16;              // magnitude bits after prescale
   localparam int PRE_W     = PRE_BITS + 1;    // signed prescaled component
   localparam int PP_W      = 2 * PRE_W;       // signed product of two components
   localparam int NN_W      = PP_W + 1;        // sum of three products
   localparam int PROD_W    = NN_W + PRE_W;    // nn * d or dn * n
   localparam int R_W       = PROD_W + 2;      // nn * d - 2 * dn * n
   localparam int RMAG_W    = R_W - 1;
   localparam int RLEN_W    = $clog2(RMAG_W + 1);
   localparam int NORM_BITS = 30;
   localparam int SQ_W      = 2 * NORM_BITS;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;

   // position of the highest set bit plus one
   function automatic logic [RLEN_W-1:0] rmag_len(input logic [RMAG_W-1:0] v);
      logic [RLEN_W-1:0] len;
      len = '0;
      for (int i = 0; i < RMAG_W; i++) begin
         if (v[i]) len = RLEN_W'(i + 1);
      end
      return len;
   endfunction

endpackage

>>> rtl/rrd_isqrt.sv
// pipelined integer square root, two result bits per stage, with side payload
module rrd_isqrt import rrd_pkg::*; #(
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SUM_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int ST = (ROOT_W + 1) / 2;

   logic              v_ff    [ST];
   logic [SUM_W-1:0]  x_ff    [ST];
   logic [SUM_W-1:0]  r_ff    [ST];
   logic [SIDE_W-1:0] side_ff [ST];
   logic [SUM_W-1:0]  x_in    [ST];
   logic [SUM_W-1:0]  r_in    [ST];
   logic              en      [ST+1];

   assign en[ST] = out_ready;

   for (genvar s = 0; s < ST; s++) begin : g_st
      logic              v_src;
      logic [SUM_W-1:0]  x_src;
      logic [SUM_W-1:0]  r_src;
      logic [SIDE_W-1:0] side_src;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign x_src    = in_rad;
         assign r_src    = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign x_src    = x_ff[s-1];
         assign r_src    = r_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      assign en[s] = !v_ff[s] || en[s+1];

      always_comb begin
         logic [SUM_W-1:0] x;
         logic [SUM_W-1:0] r;
         logic [SUM_W-1:0] b;
         logic [SUM_W-1:0] t;
         x = x_src;
         r = r_src;
         for (int j = 0; j < 2; j++) begin
            if (2 * s + j < ROOT_W) begin
               b = SUM_W'(1) << (2 * (ROOT_W - 1 - (2 * s + j)));
               t = r + b;
               if (x >= t) begin
                  x = x - t;
                  r = (r >> 1) + b;
               end else begin
                  r = r >> 1;
               end
            end
         end
         x_in[s] = x;
         r_in[s] = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            x_ff[s]    <= x_in[s];
            r_ff[s]    <= r_in[s];
            side_ff[s] <= side_src;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[ST-1];
   assign out_root  = r_ff[ST-1][ROOT_W-1:0];
   assign out_side  = side_ff[ST-1];

endmodule

>>> rtl/reflect_ray_direction.sv
// top level: mirror reflection of a ray direction with unit-length result
//
// req channel: one transfer per hit, carrying the incoming direction, the
// surface normal (any length) and the hit point, all signed fixed point.
// rsp channel: one transfer per hit, carrying the reflected direction scaled
// to unit length, the hit point as the new origin and a degenerate flag in
// tuser (set, with a zero direction, when the normal or direction is zero).
// The block is a stall-aware pipeline: one hit may enter every cycle and
// results leave in arrival order, one per cycle at full rate.
// The square-root and divider stages each produce two result bits per stage.
// Each stage moves on when it is empty or the stage after it moves, so a
// stalled receiver fills the bubbles first and then holds req_tready low;
// nothing is lost or repeated. Reset empties every stage.
module reflect_ray_direction import rrd_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // incoming_dir_x/y/z, normal_x/y/z, hit_x/y/z, COORD_BITS each, then zero fill
   input  logic [((9*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // reflect_dir_x/y/z (FRAC_BITS+2 each), origin_x/y/z (COORD_BITS each), zero fill
   output logic [((3*(FRAC_BITS+2)+3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic rsp_tuser
);

   localparam int C      = COORD_BITS;
   localparam int F      = FRAC_BITS;
   localparam int LW     = $clog2(C + 1);
   localparam int DIR_W  = F + 2;
   localparam int Q_W    = F + 1;
   localparam int N_W    = NORM_BITS + F + 1;
   localparam int REM_W  = ROOT_W;
   localparam int OUT_W  = ((3 * DIR_W + 3 * C + 7) / 8) * 8;
   localparam int PAD_W  = OUT_W - 3 * DIR_W - 3 * C;
   localparam int SIDE_W = 3 * NORM_BITS + 3 + 1 + 3 * C;
   localparam int DST    = (Q_W + 1) / 2;

   function automatic logic [LW-1:0] coord_len(input logic [C-1:0] v);
      logic [LW-1:0] len;
      len = '0;
      for (int i = 0; i < C; i++) begin
         if (v[i]) len = LW'(i + 1);
      end
      return len;
   endfunction

   // stage 1: sign and magnitude
   logic         a_v_ff;
   logic [C-1:0] a_dmag_ff [3], a_nmag_ff [3], a_org_ff [3];
   logic         a_dsgn_ff [3], a_nsgn_ff [3];
   logic [C-1:0] a_dmag_in [3], a_nmag_in [3];
   logic         en1;

   // stage 2: prescaled vectors
   logic                    b_v_ff;
   logic signed [PRE_W-1:0] b_d_ff [3], b_n_ff [3];
   logic signed [PRE_W-1:0] b_d_in [3], b_n_in [3];
   logic [C-1:0]            b_org_ff [3];
   logic                    en2;

   // stage 3: component products
   logic                    c_v_ff;
   logic signed [PP_W-1:0]  c_dn_ff [3], c_nn_ff [3];
   logic signed [PRE_W-1:0] c_d_ff [3], c_n_ff [3];
   logic [C-1:0]            c_org_ff [3];
   logic                    en3;

   // stage 4: dot products
   logic                    e_v_ff;
   logic signed [NN_W-1:0]  e_nn_ff, e_dn_ff;
   logic signed [PRE_W-1:0] e_d_ff [3], e_n_ff [3];
   logic                    e_degen_ff;
   logic [C-1:0]            e_org_ff [3];
   logic                    en4;

   // stage 5: scaled products
   logic                     f_v_ff;
   logic signed [PROD_W-1:0] f_pa_ff [3], f_pb_ff [3];
   logic                     f_degen_ff;
   logic [C-1:0]             f_org_ff [3];
   logic                     en5;

   // stage 6: reflected vector magnitudes
   logic                  g_v_ff;
   logic [RMAG_W-1:0]     g_mag_ff [3];
   logic [RMAG_W-1:0]     g_mag_in [3];
   logic                  g_sgn_ff [3], g_sgn_in [3];
   logic                  g_degen_ff;
   logic [C-1:0]          g_org_ff [3];
   logic                  en6;

   // stage 7: bit length
   logic                  h_v_ff;
   logic [RMAG_W-1:0]     h_mag_ff [3];
   logic [RLEN_W-1:0]     h_len_ff;
   logic                  h_sgn_ff [3];
   logic                  h_degen_ff;
   logic [C-1:0]          h_org_ff [3];
   logic                  en7;

   // stage 8: normalised magnitudes
   logic                  i_v_ff;
   logic [NORM_BITS-1:0]  i_mag_ff [3], i_mag_in [3];
   logic                  i_sgn_ff [3];
   logic                  i_degen_ff;
   logic [C-1:0]          i_org_ff [3];
   logic                  en8;

   // stage 9: squares
   logic                  j_v_ff;
   logic [SQ_W-1:0]       j_sq_ff [3];
   logic [NORM_BITS-1:0]  j_mag_ff [3];
   logic                  j_sgn_ff [3];
   logic                  j_degen_ff;
   logic [C-1:0]          j_org_ff [3];
   logic                  en9;

   // stage 10: sum of squares
   logic                  k_v_ff;
   logic [SUM_W-1:0]      k_sum_ff;
   logic [NORM_BITS-1:0]  k_mag_ff [3];
   logic                  k_sgn_ff [3];
   logic                  k_degen_ff;
   logic [C-1:0]          k_org_ff [3];
   logic                  en10;

   // square root
   logic                  sq_in_ready, sq_out_valid;
   logic [ROOT_W-1:0]     sq_root;
   logic [SIDE_W-1:0]     sq_in_side, sq_out_side;
   logic [NORM_BITS-1:0]  sq_mag [3];
   logic                  sq_sgn [3];
   logic                  sq_degen;
   logic [C-1:0]          sq_org [3];

   // stage 11: divider setup
   logic                  m_v_ff;
   logic [REM_W-1:0]      m_div_ff, m_div_in;
   logic [REM_W-1:0]      m_rem_ff [3], m_rem_in [3];
   logic [Q_W-1:0]        m_q_ff [3], m_q_in [3];
   logic                  m_sgn_ff [3];
   logic                  m_degen_ff;
   logic [C-1:0]          m_org_ff [3];
   logic                  en11;

   // divider stages
   logic                  dv_ff    [DST];
   logic [REM_W-1:0]      ddiv_ff  [DST];
   logic [REM_W-1:0]      drem_ff  [DST][3];
   logic [Q_W-1:0]        dq_ff    [DST][3];
   logic [REM_W-1:0]      drem_in  [DST][3];
   logic [Q_W-1:0]        dq_in    [DST][3];
   logic                  dsgn_ff  [DST][3];
   logic                  ddegen_ff[DST];
   logic [C-1:0]          dorg_ff  [DST][3];
   logic                  den      [DST+1];

   // output register
   logic                  o_v_ff;
   logic [DIR_W-1:0]      o_dir_ff [3], o_dir_in [3];
   logic                  o_degen_ff;
   logic [C-1:0]          o_org_ff [3];
   logic                  en_out;

   // ready chain, back to front
   assign en_out   = !o_v_ff || rsp_tready;
   assign den[DST] = en_out;
   assign en11 = !m_v_ff || den[0];
   assign en10 = !k_v_ff || sq_in_ready;
   assign en9  = !j_v_ff || en10;
   assign en8  = !i_v_ff || en9;
   assign en7  = !h_v_ff || en8;
   assign en6  = !g_v_ff || en7;
   assign en5  = !f_v_ff || en6;
   assign en4  = !e_v_ff || en5;
   assign en3  = !c_v_ff || en4;
   assign en2  = !b_v_ff || en3;
   assign en1  = !a_v_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
         k_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (en1)    a_v_ff <= req_tvalid;
         if (en2)    b_v_ff <= a_v_ff;
         if (en3)    c_v_ff <= b_v_ff;
         if (en4)    e_v_ff <= c_v_ff;
         if (en5)    f_v_ff <= e_v_ff;
         if (en6)    g_v_ff <= f_v_ff;
         if (en7)    h_v_ff <= g_v_ff;
         if (en8)    i_v_ff <= h_v_ff;
         if (en9)    j_v_ff <= i_v_ff;
         if (en10)   k_v_ff <= j_v_ff;
         if (en11)   m_v_ff <= sq_out_valid;
         if (en_out) o_v_ff <= dv_ff[DST-1];
      end
   end

   // stage 1
   always_comb begin
      logic [C-1:0] rd, rn;
      for (int i = 0; i < 3; i++) begin
         rd = req_tdata[i*C +: C];
         rn = req_tdata[(3+i)*C +: C];
         a_dmag_in[i] = rd[C-1] ? (~rd + C'(1)) : rd;
         a_nmag_in[i] = rn[C-1] ? (~rn + C'(1)) : rn;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 3; i++) begin
            a_dmag_ff[i] <= a_dmag_in[i];
            a_nmag_ff[i] <= a_nmag_in[i];
            a_dsgn_ff[i] <= req_tdata[i*C + C - 1];
            a_nsgn_ff[i] <= req_tdata[(3+i)*C + C - 1];
            a_org_ff[i]  <= req_tdata[(6+i)*C +: C];
         end
      end
   end

   // stage 2: shift both vectors down to PRE_BITS magnitude bits
   always_comb begin
      logic [LW-1:0] dl, nl, ds, ns;
      logic [C-1:0]  t;
      dl = coord_len(a_dmag_ff[0] | a_dmag_ff[1] | a_dmag_ff[2]);
      nl = coord_len(a_nmag_ff[0] | a_nmag_ff[1] | a_nmag_ff[2]);
      ds = (dl > LW'(PRE_BITS)) ? dl - LW'(PRE_BITS) : '0;
      ns = (nl > LW'(PRE_BITS)) ? nl - LW'(PRE_BITS) : '0;
      for (int i = 0; i < 3; i++) begin
         t = a_dmag_ff[i] >> ds;
         b_d_in[i] = a_dsgn_ff[i] ? -$signed({1'b0, t[PRE_BITS-1:0]})
                                  : $signed({1'b0, t[PRE_BITS-1:0]});
         t = a_nmag_ff[i] >> ns;
         b_n_in[i] = a_nsgn_ff[i] ? -$signed({1'b0, t[PRE_BITS-1:0]})
                                  : $signed({1'b0, t[PRE_BITS-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         b_d_ff   <= b_d_in;
         b_n_ff   <= b_n_in;
         b_org_ff <= a_org_ff;
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (en3) begin
         for (int i = 0; i < 3; i++) begin
            c_dn_ff[i] <= b_d_ff[i] * b_n_ff[i];
            c_nn_ff[i] <= b_n_ff[i] * b_n_ff[i];
         end
         c_d_ff   <= b_d_ff;
         c_n_ff   <= b_n_ff;
         c_org_ff <= b_org_ff;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (en4) begin
         e_nn_ff <= NN_W'(c_nn_ff[0]) + NN_W'(c_nn_ff[1]) + NN_W'(c_nn_ff[2]);
         e_dn_ff <= NN_W'(c_dn_ff[0]) + NN_W'(c_dn_ff[1]) + NN_W'(c_dn_ff[2]);
         e_degen_ff <= (c_n_ff[0] == '0 && c_n_ff[1] == '0 && c_n_ff[2] == '0)
                    || (c_d_ff[0] == '0 && c_d_ff[1] == '0 && c_d_ff[2] == '0);
         e_d_ff   <= c_d_ff;
         e_n_ff   <= c_n_ff;
         e_org_ff <= c_org_ff;
      end
   end

   // stage 5
   always_ff @(posedge clock) begin
      if (en5) begin
         for (int i = 0; i < 3; i++) begin
            f_pa_ff[i] <= e_nn_ff * e_d_ff[i];
            f_pb_ff[i] <= e_dn_ff * e_n_ff[i];
         end
         f_degen_ff <= e_degen_ff;
         f_org_ff   <= e_org_ff;
      end
   end

   // stage 6: r = nn d - 2 dn n
   always_comb begin
      logic signed [R_W-1:0] r;
      for (int i = 0; i < 3; i++) begin
         r = R_W'(f_pa_ff[i]) - (R_W'(f_pb_ff[i]) <<< 1);
         g_sgn_in[i] = r[R_W-1];
         g_mag_in[i] = r[R_W-1] ? RMAG_W'(-r) : r[RMAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         g_mag_ff   <= g_mag_in;
         g_sgn_ff   <= g_sgn_in;
         g_degen_ff <= f_degen_ff;
         g_org_ff   <= f_org_ff;
      end
   end

   // stage 7
   always_ff @(posedge clock) begin
      if (en7) begin
         h_len_ff   <= rmag_len(g_mag_ff[0] | g_mag_ff[1] | g_mag_ff[2]);
         h_mag_ff   <= g_mag_ff;
         h_sgn_ff   <= g_sgn_ff;
         h_degen_ff <= g_degen_ff;
         h_org_ff   <= g_org_ff;
      end
   end

   // stage 8: bring the largest component to NORM_BITS bits
   always_comb begin
      logic [RMAG_W-1:0] t;
      for (int i = 0; i < 3; i++) begin
         if (h_len_ff > RLEN_W'(NORM_BITS)) begin
            t = h_mag_ff[i] >> (h_len_ff - RLEN_W'(NORM_BITS));
         end else begin
            t = h_mag_ff[i] << (RLEN_W'(NORM_BITS) - h_len_ff);
         end
         i_mag_in[i] = t[NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en8) begin
         i_mag_ff   <= i_mag_in;
         i_sgn_ff   <= h_sgn_ff;
         i_degen_ff <= h_degen_ff;
         i_org_ff   <= h_org_ff;
      end
   end

   // stage 9
   always_ff @(posedge clock) begin
      if (en9) begin
         for (int i = 0; i < 3; i++) begin
            j_sq_ff[i] <= i_mag_ff[i] * i_mag_ff[i];
         end
         j_mag_ff   <= i_mag_ff;
         j_sgn_ff   <= i_sgn_ff;
         j_degen_ff <= i_degen_ff;
         j_org_ff   <= i_org_ff;
      end
   end

   // stage 10
   always_ff @(posedge clock) begin
      if (en10) begin
         k_sum_ff <= SUM_W'(j_sq_ff[0]) + SUM_W'(j_sq_ff[1]) + SUM_W'(j_sq_ff[2]);
         k_mag_ff   <= j_mag_ff;
         k_sgn_ff   <= j_sgn_ff;
         k_degen_ff <= j_degen_ff;
         k_org_ff   <= j_org_ff;
      end
   end

   assign sq_in_side = {k_org_ff[2], k_org_ff[1], k_org_ff[0], k_degen_ff,
                        k_sgn_ff[2], k_sgn_ff[1], k_sgn_ff[0],
                        k_mag_ff[2], k_mag_ff[1], k_mag_ff[0]};

   rrd_isqrt #(
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k_v_ff),
      .in_ready  (sq_in_ready),
      .in_rad    (k_sum_ff),
      .in_side   (sq_in_side),
      .out_valid (sq_out_valid),
      .out_ready (en11),
      .out_root  (sq_root),
      .out_side  (sq_out_side)
   );

   assign {sq_org[2], sq_org[1], sq_org[0], sq_degen,
           sq_sgn[2], sq_sgn[1], sq_sgn[0],
           sq_mag[2], sq_mag[1], sq_mag[0]} = sq_out_side;

   // stage 11: rounded numerator, top part as the starting remainder
   always_comb begin
      logic [N_W-1:0] num;
      m_div_in = (sq_root == '0) ? REM_W'(1) : sq_root;
      for (int i = 0; i < 3; i++) begin
         num = N_W'({sq_mag[i], {F{1'b0}}}) + N_W'(m_div_in >> 1);
         m_rem_in[i] = REM_W'(num[N_W-1:Q_W]);
         m_q_in[i]   = num[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en11) begin
         m_div_ff   <= m_div_in;
         m_rem_ff   <= m_rem_in;
         m_q_ff     <= m_q_in;
         m_sgn_ff   <= sq_sgn;
         m_degen_ff <= sq_degen;
         m_org_ff   <= sq_org;
      end
   end

   // restoring divider, numerator bits shift out of the top of q as quotient bits enter
   for (genvar s = 0; s < DST; s++) begin : g_div
      logic              v_src;
      logic [REM_W-1:0]  div_src;
      logic [REM_W-1:0]  rem_src [3];
      logic [Q_W-1:0]    q_src [3];
      logic              sgn_src [3];
      logic              degen_src;
      logic [C-1:0]      org_src [3];

      if (s == 0) begin : g_first
         assign v_src     = m_v_ff;
         assign div_src   = m_div_ff;
         assign rem_src   = m_rem_ff;
         assign q_src     = m_q_ff;
         assign sgn_src   = m_sgn_ff;
         assign degen_src = m_degen_ff;
         assign org_src   = m_org_ff;
      end else begin : g_next
         assign v_src     = dv_ff[s-1];
         assign div_src   = ddiv_ff[s-1];
         assign rem_src   = drem_ff[s-1];
         assign q_src     = dq_ff[s-1];
         assign sgn_src   = dsgn_ff[s-1];
         assign degen_src = ddegen_ff[s-1];
         assign org_src   = dorg_ff[s-1];
      end

      assign den[s] = !dv_ff[s] || den[s+1];

      always_comb begin
         logic [REM_W:0]   t;
         logic [REM_W-1:0] rem;
         logic [Q_W-1:0]   q;
         for (int i = 0; i < 3; i++) begin
            rem = rem_src[i];
            q   = q_src[i];
            for (int j = 0; j < 2; j++) begin
               if (2 * s + j < Q_W) begin
                  t = {rem, q[Q_W-1]};
                  if (t >= {1'b0, div_src}) begin
                     t = t - {1'b0, div_src};
                     q = {q[Q_W-2:0], 1'b1};
                  end else begin
                     q = {q[Q_W-2:0], 1'b0};
                  end
                  rem = t[REM_W-1:0];
               end
            end
            drem_in[s][i] = rem;
            dq_in[s][i]   = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (den[s]) begin
            dv_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (den[s]) begin
            ddiv_ff[s]   <= div_src;
            drem_ff[s]   <= drem_in[s];
            dq_ff[s]     <= dq_in[s];
            dsgn_ff[s]   <= sgn_src;
            ddegen_ff[s] <= degen_src;
            dorg_ff[s]   <= org_src;
         end
      end
   end

   // saturate at unit, restore sign, zero on degenerate input
   always_comb begin
      logic [Q_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = dq_ff[DST-1][i];
         if (q > Q_W'(1) << F) q = Q_W'(1) << F;
         if (ddegen_ff[DST-1]) begin
            o_dir_in[i] = '0;
         end else if (dsgn_ff[DST-1][i]) begin
            o_dir_in[i] = -{1'b0, q};
         end else begin
            o_dir_in[i] = {1'b0, q};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         o_dir_ff   <= o_dir_in;
         o_degen_ff <= ddegen_ff[DST-1];
         o_org_ff   <= dorg_ff[DST-1];
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tuser  = o_degen_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, o_org_ff[2], o_org_ff[1], o_org_ff[0],
                        o_dir_ff[2], o_dir_ff[1], o_dir_ff[0]};

endmodule

>>> tb/sv/testbench.sv
// stream testbench for the reflected ray direction pipeline
module testbench;
   import rrd_pkg::*;

   localparam int FRAC   = 16;
   localparam int COORD  = 32;
   localparam int DIR_W  = FRAC + 2;
   localparam int REQ_W  = ((9*COORD+7)/8)*8;
   localparam int RSP_W  = ((3*DIR_W+3*COORD+7)/8)*8;
   localparam int LATENCY = 37;
   localparam int IDLE_LIMIT = 4000;
   localparam int N_RANDOM = 1330;

   typedef struct packed {
      logic signed [COORD-1:0] hz, hy, hx, nz, ny, nx, dz, dy, dx;
   } hit_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] rx, ry, rz;
      logic signed [COORD-1:0] ox, oy, oz;
      logic degen;
   } bounce_type;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tuser;
   logic [REQ_W-1:0] req_tdata;
   logic [RSP_W-1:0] rsp_tdata;

   reflect_ray_direction #(.FRAC_BITS(FRAC), .COORD_BITS(COORD)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   hit_type    pending_hits[$];
   bounce_type expected_bounces[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      hold_off = 0;
   bit      stimulus_done = 0;
   // transfers seen at the last rising edge
   bit      req_taken = 0;
   bit      rsp_taken = 0;

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   function automatic int unsigned bitlen(logic [63:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
      return n;
   endfunction

   // shrink a vector to at most 16 magnitude bits, sign kept
   function automatic void shrink(input logic signed [COORD-1:0] a,
         input logic signed [COORD-1:0] b, input logic signed [COORD-1:0] c,
         output longint o0, output longint o1, output longint o2);
      logic [63:0] m0, m1, m2, mx;
      int unsigned l, sh;
      m0 = a[COORD-1] ? -longint'(a) : longint'(a);
      m1 = b[COORD-1] ? -longint'(b) : longint'(b);
      m2 = c[COORD-1] ? -longint'(c) : longint'(c);
      mx = m0;
      if (m1 > mx) mx = m1;
      if (m2 > mx) mx = m2;
      l = bitlen(mx);
      sh = (l > 16) ? l - 16 : 0;
      o0 = a[COORD-1] ? -longint'(m0 >> sh) : longint'(m0 >> sh);
      o1 = b[COORD-1] ? -longint'(m1 >> sh) : longint'(m1 >> sh);
      o2 = c[COORD-1] ? -longint'(m2 >> sh) : longint'(m2 >> sh);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bounce_type reflect_hit(hit_type h);
      bounce_type res;
      longint d[3], n[3], nn, dn, r;
      logic [63:0] mag[3], mx, total, m, q;
      logic neg[3];
      int unsigned l;
      res.ox = h.hx; res.oy = h.hy; res.oz = h.hz;
      res.rx = '0; res.ry = '0; res.rz = '0;
      res.degen = 1'b1;
      shrink(h.dx, h.dy, h.dz, d[0], d[1], d[2]);
      shrink(h.nx, h.ny, h.nz, n[0], n[1], n[2]);
      nn = 0; dn = 0;
      for (int i = 0; i < 3; i++) begin
         nn += n[i] * n[i];
         dn += d[i] * n[i];
      end
      if (nn == 0 || (d[0] == 0 && d[1] == 0 && d[2] == 0)) return res;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         r = nn * d[i] - 2 * dn * n[i];
         neg[i] = r < 0;
         mag[i] = neg[i] ? -r : r;
         if (mag[i] > mx) mx = mag[i];
      end
      l = bitlen(mx);
      total = 0;
      for (int i = 0; i < 3; i++) begin
         if (l > 30) mag[i] = mag[i] >> (l - 30);
         else mag[i] = mag[i] << (30 - l);
         total += mag[i] * mag[i];
      end
      m = root_floor(total);
      if (m == 0) m = 1;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FRAC) + (m >> 1)) / m;
         if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
         if (neg[i]) q = -q;
         if (i == 0) res.rx = q[DIR_W-1:0];
         else if (i == 1) res.ry = q[DIR_W-1:0];
         else res.rz = q[DIR_W-1:0];
      end
      res.degen = 1'b0;
      return res;
   endfunction

   function automatic void queue_hit(hit_type h);
      pending_hits.insert(pending_hits.size(), h);
   endfunction

   // driver: new item offered after a random gap, changes at falling edge
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the current transfer
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_hits.size() > 0) begin
         req_tdata <= REQ_W'(pending_hits.pop_front());
         req_tvalid <= 1'b1;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver: random stalls, plus one long hold-off
   int recv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on input transfer, check on output transfer
   always @(posedge clock) begin
      bounce_type want, got;
      logic busy;
      busy = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            expected_bounces.insert(expected_bounces.size(),
               reflect_hit(hit_type'(req_tdata[9*COORD-1:0])));
            busy = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            got.rx = rsp_tdata[DIR_W-1:0];
            got.ry = rsp_tdata[2*DIR_W-1:DIR_W];
            got.rz = rsp_tdata[3*DIR_W-1:2*DIR_W];
            got.ox = rsp_tdata[3*DIR_W+COORD-1:3*DIR_W];
            got.oy = rsp_tdata[3*DIR_W+2*COORD-1:3*DIR_W+COORD];
            got.oz = rsp_tdata[3*DIR_W+3*COORD-1:3*DIR_W+2*COORD];
            got.degen = rsp_tuser;
            if (expected_bounces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
               want = expected_bounces.pop_front();
               if (want != got) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("mismatch: exp dir %0d %0d %0d org %0d %0d %0d deg %0d, ",
                        want.rx, want.ry, want.rz, want.ox, want.oy, want.oz,
                        want.degen);
                     $display("got dir %0d %0d %0d org %0d %0d %0d deg %0d",
                        got.rx, got.ry, got.rz, got.ox, got.oy, got.oz,
                        got.degen);
                  end
               end
            end
         end
         idle_cycles <= busy ? 0 : idle_cycles + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("reflect_ray_direction test failed");
         $finish;
      end
   end

   function automatic logic [COORD-1:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return COORD'($signed($urandom_range(0, 2 * 65536)) - 65536);
         2: return COORD'($signed($urandom_range(0, 200)) - 100);
         3: return $urandom() >> $urandom_range(0, 31);
         default: return -($urandom() >> $urandom_range(0, 31));
      endcase
   endfunction

   function automatic hit_type rand_hit();
      hit_type h;
      h.dx = rand_coord(); h.dy = rand_coord(); h.dz = rand_coord();
      h.nx = rand_coord(); h.ny = rand_coord(); h.nz = rand_coord();
      h.hx = $urandom(); h.hy = $urandom(); h.hz = $urandom();
      case ($urandom_range(0, 19))
         0: begin h.nx = 0; h.ny = 0; h.nz = 0; end
         1: begin h.dx = 0; h.dy = 0; h.dz = 0; end
         default: ;
      endcase
      return h;
   endfunction

   function automatic hit_type mk(int dx, int dy, int dz, int nx, int ny, int nz);
      hit_type h;
      h.dx = dx; h.dy = dy; h.dz = dz;
      h.nx = nx; h.ny = ny; h.nz = nz;
      h.hx = $urandom(); h.hy = $urandom(); h.hz = $urandom();
      return h;
   endfunction

   localparam int ONE = 65536;
   localparam int MINV = 32'h8000_0000;
   localparam int MAXV = 32'h7fff_ffff;

   initial begin
      hit_type h;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: axis bounces, zero normal, zero direction, extremes
      queue_hit(mk(ONE, -ONE, 0, 0, ONE, 0));
      queue_hit(mk(0, 0, -ONE, 0, 0, ONE));
      queue_hit(mk(ONE, ONE, ONE, 0, 0, 0));
      queue_hit(mk(0, 0, 0, 0, ONE, 0));
      queue_hit(mk(0, 0, 0, 0, 0, 0));
      queue_hit(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      queue_hit(mk(MINV, MINV, MINV, MINV, MINV, MINV));
      queue_hit(mk(MINV, MAXV, 0, MAXV, MINV, 1));
      queue_hit(mk(1, 0, 0, 0, 1, 0));
      queue_hit(mk(-1, -1, -1, 1, 1, 1));
      queue_hit(mk(ONE, 0, 0, 3 * ONE, 0, 0));
      queue_hit(mk(MAXV, 1, -1, -1, MINV, 5));
      h = mk(-1, -1, -1, -1, -1, -1);
      h.hx = MINV; h.hy = MAXV; h.hz = -1;
      queue_hit(h);
      h = mk(ONE, 2, 3, -ONE, 7, 9);
      h.hx = 0; h.hy = MINV; h.hz = MAXV;
      queue_hit(h);
      for (int i = 0; i < N_RANDOM; i++) begin
         queue_hit(rand_hit());
         // long receiver stall part way through so the pipeline backs up
         if (i == 300) begin
            wait (pending_hits.size() < 100);
            hold_off = 400;
         end
      end
      wait (pending_hits.size() == 0 && !req_tvalid);
      wait (expected_bounces.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_bounces.size() == 0)
         $display("reflect_ray_direction test passed");
      else
         $display("reflect_ray_direction test failed");
      $finish;
   end

endmodule
